/* design/arhp_pkg.sv */
package arhp_pkg;

    // record framing
    localparam logic [7:0] MAGIC_BYTE   = 8'h42;
    localparam int         MODE_BYTES   = 3;
    localparam int         NAMELEN_BYTES = 2;
    localparam int         CONTLEN_BYTES = 6;

    // parse phase of the current record
    typedef enum logic [2:0] {
        PH_MAGIC   = 3'd0,
        PH_MODE    = 3'd1,
        PH_NAMELEN = 3'd2,
        PH_CONTLEN = 3'd3,
        PH_NAME    = 3'd4,
        PH_CONTENT = 3'd5,
        PH_HASH    = 3'd6,
        PH_FAILED  = 3'd7
    } t_phase;

    // result kind codes
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_NAME   = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    // one result item
    typedef struct packed {
        t_kind        kind;
        logic [23:0]  mode_bits;
        logic [15:0]  name_length;
        logic [47:0]  body_length;
        logic [7:0]   name_char;
        logic         last_name_char;
    } t_result;

endpackage

/* design/archive_record_header_parser.sv */
// archive record header parser
// input channel: i_data_valid / i_data_byte, stalled by o_data_stall; one
// archive byte per item. output channel: o_res_valid with the result fields,
// stalled by i_res_stall. a record header item (kind 0) follows the last
// content-length byte, one name item (kind 1) follows each name byte with
// o_last_name_char on the final one, and a bad magic byte gives one error
// item (kind 2) after which all bytes are taken and dropped until reset.
// a byte accepted into the input item register is parsed once the result
// item register is free, and its result is registered there for o_res_valid.
// throughput: one byte per cycle while i_res_stall is low; the only per-byte
// work is a shift into a field register and a 48-bit down count.
// reset (synchronous, i_rst_n low) empties both item registers and returns
// the parser to waiting for a magic byte.
// when the receiver stalls, the result register holds its item, the parser
// holds the next byte, and o_data_stall rises once that byte is also held.
module archive_record_header_parser
    import arhp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_data_valid,
    input  logic [7:0]    i_data_byte,
    output logic          o_data_stall,
    output logic          o_res_valid,
    input  logic          i_res_stall,
    output logic [1:0]    o_kind,
    output logic [23:0]   o_mode_bits,
    output logic [15:0]   o_name_length,
    output logic [47:0]   o_body_length,
    output logic [7:0]    o_name_char,
    output logic          o_last_name_char
);

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         out_free;
    logic         step;
    logic         in_free;
    logic         core_valid;
    t_result      core_res;
    t_result      out_res;

    // parse the held byte when the result register can take its item
    assign step         = r_in_valid && out_free;
    assign in_free      = !r_in_valid || step;
    assign o_data_stall = !in_free;

    // input item register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_data_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_data_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    // record parser
    arhp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .o_res_valid (core_valid),
        .o_res       (core_res)
    );

    // result item register
    arhp_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step),
        .i_res_valid (core_valid),
        .i_res       (core_res),
        .i_stall     (i_res_stall),
        .o_free      (out_free),
        .o_valid     (o_res_valid),
        .o_res       (out_res)
    );

    assign o_kind           = out_res.kind;
    assign o_mode_bits      = out_res.mode_bits;
    assign o_name_length    = out_res.name_length;
    assign o_body_length    = out_res.body_length;
    assign o_name_char      = out_res.name_char;
    assign o_last_name_char = out_res.last_name_char;

endmodule

/* design/arhp_parse_core.sv */
module arhp_parse_core
    import arhp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [7:0]    i_byte,
    output logic          o_res_valid,
    output t_result       o_res
);

    t_phase       r_phase,      n_phase;
    logic [3:0]   r_field_cnt,  n_field_cnt;
    logic [23:0]  r_mode,       n_mode;
    logic [15:0]  r_name_len,   n_name_len;
    logic [47:0]  r_cont_len,   n_cont_len;
    logic [47:0]  r_remaining,  n_remaining;
    logic         remaining_le1;

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAGIC;
            r_field_cnt <= '0;
            r_mode      <= '0;
            r_name_len  <= '0;
            r_cont_len  <= '0;
            r_remaining <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_field_cnt <= n_field_cnt;
            r_mode      <= n_mode;
            r_name_len  <= n_name_len;
            r_cont_len  <= n_cont_len;
            r_remaining <= n_remaining;
        end
    end

    assign remaining_le1 = (r_remaining[47:1] == 47'd0);

    // next state and result for the byte in hand
    always_comb begin
        n_phase     = r_phase;
        n_field_cnt = r_field_cnt;
        n_mode      = r_mode;
        n_name_len  = r_name_len;
        n_cont_len  = r_cont_len;
        n_remaining = r_remaining;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (r_phase)
            PH_MAGIC: begin
                if (i_byte != MAGIC_BYTE) begin
                    n_phase     = PH_FAILED;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_ERROR;
                end else begin
                    n_mode      = '0;
                    n_name_len  = '0;
                    n_cont_len  = '0;
                    n_field_cnt = '0;
                    n_phase     = PH_MODE;
                end
            end
            PH_MODE: begin
                n_mode = {r_mode[15:0], i_byte};
                if (r_field_cnt == 4'(MODE_BYTES - 1)) begin
                    n_field_cnt = '0;
                    n_phase     = PH_NAMELEN;
                end else begin
                    n_field_cnt = r_field_cnt + 4'd1;
                end
            end
            PH_NAMELEN: begin
                n_name_len = {r_name_len[7:0], i_byte};
                if (r_field_cnt == 4'(NAMELEN_BYTES - 1)) begin
                    n_field_cnt = '0;
                    n_phase     = PH_CONTLEN;
                end else begin
                    n_field_cnt = r_field_cnt + 4'd1;
                end
            end
            PH_CONTLEN: begin
                n_cont_len = {r_cont_len[39:0], i_byte};
                if (r_field_cnt == 4'(CONTLEN_BYTES - 1)) begin
                    n_field_cnt          = '0;
                    o_res_valid          = 1'b1;
                    o_res.kind           = KIND_HEADER;
                    o_res.mode_bits      = r_mode;
                    o_res.name_length    = r_name_len;
                    o_res.body_length    = n_cont_len;
                    // empty name skips straight to content or hash
                    if (r_name_len != 16'd0) begin
                        n_remaining = {32'd0, r_name_len};
                        n_phase     = PH_NAME;
                    end else if (n_cont_len == 48'd0) begin
                        n_phase = PH_HASH;
                    end else begin
                        n_remaining = n_cont_len;
                        n_phase     = PH_CONTENT;
                    end
                end else begin
                    n_field_cnt = r_field_cnt + 4'd1;
                end
            end
            PH_NAME: begin
                o_res_valid     = 1'b1;
                o_res.kind      = KIND_NAME;
                o_res.name_char = i_byte;
                if (remaining_le1) begin
                    o_res.last_name_char = 1'b1;
                    if (r_cont_len == 48'd0) begin
                        n_remaining = '0;
                        n_phase     = PH_HASH;
                    end else begin
                        n_remaining = r_cont_len;
                        n_phase     = PH_CONTENT;
                    end
                end else begin
                    n_remaining = r_remaining - 48'd1;
                end
            end
            PH_CONTENT: begin
                if (remaining_le1) begin
                    n_remaining = '0;
                    n_phase     = PH_HASH;
                end else begin
                    n_remaining = r_remaining - 48'd1;
                end
            end
            PH_HASH: begin
                n_phase = PH_MAGIC;
            end
            PH_FAILED: begin
                n_phase = PH_FAILED;
            end
            default: begin
                n_phase = PH_FAILED;
            end
        endcase
    end

endmodule

/* design/arhp_out_reg.sv */
module arhp_out_reg
    import arhp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  logic          i_res_valid,
    input  t_result       i_res,
    input  logic          i_stall,
    output logic          o_free,
    output logic          o_valid,
    output t_result       o_res
);

    logic     r_valid;
    t_result  r_res;

    // register can take a new item when empty or being drained
    assign o_free = !r_valid || !i_stall;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_res_valid;
        end
    end

    // payload, held while stalled
    always_ff @(posedge i_clk) begin
        if (o_free && i_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
